/* hdl/base62_filename_parser_core_defines.svh */
// Assertion helpers for the filename parser.
`ifndef BASE62_FILENAME_PARSER_CORE_DEFINES_SVH
`define BASE62_FILENAME_PARSER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define B62FP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define B62FP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/b62fp_pkg.sv */
package b62fp_pkg;

    localparam int CODE_W    = 64;
    localparam int EXT_W     = 56;
    localparam int EXT_LEN_W = 4;
    localparam int DIGIT_W   = 6;

    localparam logic [CODE_W-1:0]    STEM_LIMIT    = 64'h0BA5_CA53_92CB_0400;
    localparam logic [EXT_LEN_W-1:0] EXT_MAX_BYTES = 4'd7;
    localparam logic [EXT_LEN_W-1:0] EXT_LEN_SAT   = 4'd8;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_0     = 8'h30;
    localparam logic [7:0] CHAR_9     = 8'h39;
    localparam logic [7:0] CHAR_UP_A  = 8'h41;
    localparam logic [7:0] CHAR_UP_Z  = 8'h5A;
    localparam logic [7:0] CHAR_LOW_A = 8'h61;
    localparam logic [7:0] CHAR_LOW_Z = 8'h7A;

    localparam logic [7:0] LOW_OFFSET = 8'd10;
    localparam logic [7:0] UP_OFFSET  = 8'd36;

    typedef struct packed {
        logic [CODE_W-1:0]    code;
        logic [CODE_W-1:0]    weight;
        logic                 in_ext;
        logic [EXT_LEN_W-1:0] ext_len;
        logic [EXT_W-1:0]     ext;
        logic                 err;
    } t_state;

    typedef struct packed {
        logic [CODE_W-1:0] name_code;
        logic [EXT_W-1:0]  ext_bytes;
        logic              ok;
    } t_result;

    typedef struct packed {
        logic               vld;
        logic [DIGIT_W-1:0] val;
    } t_digit;

    localparam t_state STATE_RESET = '{
        code:    '0,
        weight:  64'd1,
        in_ext:  1'b0,
        ext_len: '0,
        ext:     '0,
        err:     1'b0
    };

    function automatic t_digit digit_of(input logic [7:0] ch);
        t_digit     d;
        logic [7:0] v;
        v = 8'd0;
        d.vld = 1'b1;
        if (ch inside {[CHAR_0:CHAR_9]}) begin
            v = ch - CHAR_0;
        end else if (ch inside {[CHAR_LOW_A:CHAR_LOW_Z]}) begin
            v = ch - CHAR_LOW_A + LOW_OFFSET;
        end else if (ch inside {[CHAR_UP_A:CHAR_UP_Z]}) begin
            v = ch - CHAR_UP_A + UP_OFFSET;
        end else begin
            d.vld = 1'b0;
        end
        d.val = v[DIGIT_W-1:0];
        return d;
    endfunction

endpackage

/* hdl/base62_filename_parser_core.sv */
// Base-62 filename parser.
// Input channel: one character per transaction on i_in_char_byte, qualified by
// i_in_valid and held off by o_in_stall. The stem before the first '.' is
// decoded as base-62, least significant digit first; the bytes after the dot
// form the extension. A NUL character ends the name.
// Output channel: one transaction per NUL on o_out_valid / i_out_stall,
// carrying o_out_name_code, o_out_extension_bytes and o_out_ok. When ok is 0
// the code and extension are zero.
// Throughput: one character per cycle while o_in_stall is low; each character
// is decoded by a single stage between the input register and the parser
// state, using one 64x6 multiply plus a 64-bit add.
// A NUL passes through the input register and then the result register before
// its output transaction is offered.
// Receiver stall: non-NUL characters keep flowing; only a NUL waiting behind
// a stalled result raises o_in_stall.
// Reset (i_rst_n low, synchronous): both channels empty, parser state cleared
// to an empty name.
`include "base62_filename_parser_core_defines.svh"

module base62_filename_parser_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [7:0]                    i_in_char_byte,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [b62fp_pkg::CODE_W-1:0]  o_out_name_code,
    output logic [b62fp_pkg::EXT_W-1:0]   o_out_extension_bytes,
    output logic                          o_out_ok
);
    import b62fp_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_char;
    t_state     r_state;
    t_state     n_state;
    t_result    n_result;
    logic       r_out_valid;
    t_result    r_out;

    logic in_accept;
    logic in_blocked;
    logic proc;
    logic out_take;

    b62fp_next u_next (
        .i_state  (r_state),
        .i_char   (r_in_char),
        .o_state  (n_state),
        .o_result (n_result)
    );

    assign out_take   = r_out_valid && !i_out_stall;
    assign in_blocked = r_in_valid && (r_in_char == CHAR_NUL) && r_out_valid && i_out_stall;
    assign proc       = r_in_valid && !in_blocked;
    assign o_in_stall = in_blocked;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (proc) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_char <= i_in_char_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_RESET;
        end else if (proc) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc && (r_in_char == CHAR_NUL)) begin
            r_out_valid <= 1'b1;
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc && (r_in_char == CHAR_NUL)) begin
            r_out <= n_result;
        end
    end

    assign o_out_valid           = r_out_valid;
    assign o_out_name_code       = r_out.name_code;
    assign o_out_extension_bytes = r_out.ext_bytes;
    assign o_out_ok              = r_out.ok;

    `B62FP_ASSERT_NOW(a_bad_is_zero, i_clk, i_rst_n, o_out_valid && !o_out_ok,
        (o_out_name_code == '0) && (o_out_extension_bytes == '0),
        "rejected name carries nonzero payload")

    `B62FP_ASSERT_NOW(a_ok_has_ext, i_clk, i_rst_n, o_out_valid && o_out_ok,
        o_out_extension_bytes[7:0] != 8'd0, "accepted name with empty extension")

    `B62FP_ASSERT_NOW(a_stall_cause, i_clk, i_rst_n, o_in_stall,
        r_out_valid && i_out_stall && (r_in_char == CHAR_NUL),
        "input stalled without a blocked result")

    `B62FP_ASSERT_NEXT(a_nul_clears, i_clk, i_rst_n, proc && (r_in_char == CHAR_NUL),
        (r_state == STATE_RESET) && r_out_valid, "end of name did not clear state")

endmodule

/* hdl/b62fp_next.sv */
module b62fp_next (
    input  b62fp_pkg::t_state  i_state,
    input  logic [7:0]         i_char,
    output b62fp_pkg::t_state  o_state,
    output b62fp_pkg::t_result o_result
);
    import b62fp_pkg::*;

    t_digit            digit;
    logic [CODE_W-1:0] prod;
    logic [CODE_W-1:0] weight_next;
    logic              ok;
    logic [5:0]        ext_pos;

    assign digit       = digit_of(i_char);
    assign prod        = i_state.weight * {{(CODE_W-DIGIT_W){1'b0}}, digit.val};
    // weight * 62 as a shift-subtract
    assign weight_next = {i_state.weight[CODE_W-7:0], 6'd0}
                       - {i_state.weight[CODE_W-2:0], 1'b0};
    assign ext_pos     = {i_state.ext_len[2:0], 3'b000};

    assign ok = !i_state.err && i_state.in_ext && (i_state.ext_len != '0)
             && (i_state.ext_len <= EXT_MAX_BYTES);

    always_comb begin
        o_result.ok        = ok;
        o_result.name_code = ok ? i_state.code : '0;
        o_result.ext_bytes = ok ? i_state.ext : '0;
    end

    always_comb begin
        o_state = i_state;
        if (i_char == CHAR_NUL) begin
            o_state = STATE_RESET;
        end else if (i_state.err) begin
            o_state = i_state;
        end else if (!i_state.in_ext) begin
            if (i_char == CHAR_DOT) begin
                o_state.in_ext = 1'b1;
            end else if (!digit.vld || (i_state.code >= STEM_LIMIT)) begin
                o_state.err = 1'b1;
            end else begin
                o_state.code   = i_state.code + prod;
                o_state.weight = weight_next;
            end
        end else begin
            if (i_state.ext_len < EXT_MAX_BYTES) begin
                o_state.ext[ext_pos +: 8] = i_state.ext[ext_pos +: 8] | i_char;
            end
            if (i_state.ext_len < EXT_LEN_SAT) begin
                o_state.ext_len = i_state.ext_len + 4'd1;
            end
        end
    end

endmodule
